// File: src/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Word types and controller/datapath interface structs for the
// frequency-sorted batch reorder block.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      last_out;
        logic                      overflow;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // latch input word, count or drop it
        logic scan_start;  // rewind table scan, clear best pick
        logic scan_step;   // issue next table read
        logic hit_wr;      // bump count of matched entry
        logic new_wr;      // append new distinct entry
        logic emit_load;   // load one copy of the picked value into output reg
        logic mark;        // zero the picked entry's count
        logic clear;       // end of batch, clear table state
    } fss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;        // item count at capacity
        logic in_last;     // latched word closes the batch
        logic hit;         // compared entry matches current value
        logic scan_end;    // all entries read and compared
        logic rep_one;     // one copy of picked value left
        logic items_one;   // one result left in the batch
        logic out_free;    // output register can take a word
    } fss_status_t;

endpackage

// File: src/fss_dp.sv
// ----------------------------------------------------------------------------
// fss_dp
// Datapath: distinct-value and count tables, scan pipeline, best-count pick
// and output register.
// ----------------------------------------------------------------------------
module fss_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fss_pkg::in_word_t   in_word,
    input  fss_pkg::fss_cmd_t   cmd,
    output fss_pkg::fss_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output fss_pkg::out_word_t  m_data
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [fss_pkg::VALUE_W-1:0] vmem [MAX_ITEMS];
    logic [CW-1:0]               cmem [MAX_ITEMS];

    logic [fss_pkg::VALUE_W-1:0] val_reg;
    logic                        last_reg;
    logic [CW-1:0]               total_reg, total_next;
    logic [CW-1:0]               items_reg, items_next;
    logic                        drop_reg, drop_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [fss_pkg::VALUE_W-1:0] vdata_reg;
    logic [CW-1:0]               cdata_reg;
    logic [AW-1:0]               best_idx_reg, best_idx_next;
    logic [CW-1:0]               best_cnt_reg, best_cnt_next;
    logic [fss_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic                        m_valid_reg, m_valid_next;
    fss_pkg::out_word_t          m_data_reg, m_data_next;

    logic                        more;
    logic                        c_we;
    logic [AW-1:0]               c_waddr;
    logic [CW-1:0]               c_wdata;

    assign more = ptr_reg < total_reg;

    assign status.full      = (items_reg == CW'(MAX_ITEMS));
    assign status.in_last   = last_reg;
    assign status.hit       = rd_ok_reg && (vdata_reg == val_reg);
    assign status.scan_end  = !rd_ok_reg && !more;
    assign status.rep_one   = (best_cnt_reg == CW'(1));
    assign status.items_one = (items_reg == CW'(1));
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // single count-table write port
    always_comb begin
        c_we    = 1'b0;
        c_waddr = rd_idx_reg;
        c_wdata = cdata_reg + CW'(1);
        if (cmd.hit_wr) begin
            c_we = 1'b1;
        end else if (cmd.new_wr) begin
            c_we    = 1'b1;
            c_waddr = total_reg[AW-1:0];
            c_wdata = CW'(1);
        end else if (cmd.mark) begin
            c_we    = 1'b1;
            c_waddr = best_idx_reg;
            c_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.new_wr) begin
            vmem[total_reg[AW-1:0]] <= val_reg;
        end
        if (c_we) begin
            cmem[c_waddr] <= c_wdata;
        end
        vdata_reg <= vmem[ptr_reg[AW-1:0]];
        cdata_reg <= cmem[ptr_reg[AW-1:0]];
    end

    always_comb begin
        total_next    = total_reg;
        items_next    = items_reg;
        drop_next     = drop_reg;
        ptr_next      = ptr_reg;
        rd_idx_next   = rd_idx_reg;
        rd_ok_next    = rd_ok_reg;
        best_idx_next = best_idx_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cmd.take) begin
            if (status.full) begin
                drop_next = 1'b1;
            end else begin
                items_next = items_reg + CW'(1);
            end
        end

        if (cmd.scan_start) begin
            ptr_next      = '0;
            rd_ok_next    = 1'b0;
            best_cnt_next = '0;
        end else if (cmd.scan_step) begin
            rd_ok_next  = more;
            rd_idx_next = ptr_reg[AW-1:0];
            if (more) begin
                ptr_next = ptr_reg + CW'(1);
            end
            // first strictly larger count wins: ties keep arrival order
            if (rd_ok_reg && (cdata_reg > best_cnt_reg)) begin
                best_cnt_next = cdata_reg;
                best_idx_next = rd_idx_reg;
                best_val_next = vdata_reg;
            end
        end

        if (cmd.new_wr) begin
            total_next = total_reg + CW'(1);
        end

        if (cmd.emit_load) begin
            m_valid_next          = 1'b1;
            m_data_next.out_value = best_val_reg;
            m_data_next.last_out  = status.items_one;
            m_data_next.overflow  = drop_reg;
            items_next            = items_reg - CW'(1);
            best_cnt_next         = best_cnt_reg - CW'(1);
        end

        if (cmd.clear) begin
            total_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            items_reg   <= '0;
            drop_reg    <= 1'b0;
            ptr_reg     <= '0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg   <= total_next;
            items_reg   <= items_next;
            drop_reg    <= drop_next;
            ptr_reg     <= ptr_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            val_reg  <= in_word.value;
            last_reg <= in_word.last_in;
        end
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        best_val_reg <= best_val_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// File: src/fss_ctrl.sv
// ----------------------------------------------------------------------------
// fss_ctrl
// Controller: input acceptance, table search, best-count selection and
// emission sequencing.
// ----------------------------------------------------------------------------
module fss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last,
    output logic                 s_ready,
    input  fss_pkg::fss_status_t status,
    output fss_pkg::fss_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take       = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (!status.full) begin
                        state_next = ST_SCAN;
                    end else if (s_last) begin
                        // dropped word may still close the batch
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SCAN: begin
                if (status.hit || status.scan_end) begin
                    cmd.hit_wr = status.hit;
                    cmd.new_wr = !status.hit;
                    if (status.in_last) begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SEL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SEL: begin
                if (status.scan_end) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                cmd.mark = 1'b1;
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.items_one) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (status.rep_one) begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SEL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/frequency_sort_stable.sv
// ----------------------------------------------------------------------------
// frequency_sort_stable
// Batch reorder of signed 32-bit words by occurrence count, stable.
// ----------------------------------------------------------------------------
// Words of a batch are accepted one at a time; each is searched against the
// table of distinct values seen so far, one table entry per cycle through a
// registered memory read. After the word flagged last, the block picks the
// entry with the highest remaining count (earliest on ties) by a full table
// scan, sends that value as many times as it occurred, one word per cycle
// while m_ready is high, and repeats until all accepted words are sent. Words
// beyond MAX_ITEMS in a batch are dropped and every result of that batch
// carries overflow. The input is not ready while a batch is being searched,
// sorted or sent.
module frequency_sort_stable #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fss_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fss_pkg::out_word_t m_data
);

    fss_pkg::fss_cmd_t    cmd;
    fss_pkg::fss_status_t status;

    fss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_in),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fss_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_word (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
